[rtl/core/fir_pkg.sv]
// Package for the float-to-integer rounding block: types, constants, format codes.
// No dependencies.
package fir_pkg;

    localparam int unsigned ValueWidth = 64;

    // Precision select codes
    typedef enum logic {
        t_op_dbl = 1'b0,
        t_op_sgl = 1'b1
    } t_op;

    typedef struct packed {
        logic                  op;
        logic [ValueWidth-1:0] value_bits;
    } t_in_item;

    typedef struct packed {
        logic [ValueWidth-1:0] rounded;
    } t_out_item;

    localparam logic [63:0] Max64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Min64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] Max32 = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] Min32 = 64'hFFFF_FFFF_8000_0000;

endpackage

[rtl/core/fir_if.sv]
// Valid/ready channel interface carrying one payload of a given type.
// Depends on fir_pkg for the payload types.
interface fir_in_if;
    logic              valid;
    logic              ready;
    fir_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fir_out_if;
    logic               valid;
    logic               ready;
    fir_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/float_to_int_round_half_up.sv]
// Top level: IEEE-754 to signed integer, round half up, saturating.
// Depends on fir_pkg, fir_in_if, fir_out_if and fir_round.
//
//  channel  | dir | payload
//  s_in     | in  | op (1), value_bits (64)
//  m_out    | out | rounded (64, signed)
//
// One transaction per cycle while the output is not stalled; input register, then result register.
// Synchronous active-low reset clears the valid flags only.
// The input register advances whenever it is empty or the result register is empty or taken,
// so an output stall with both stages full holds both stages and deasserts ready.
module float_to_int_round_half_up (
    input  logic i_clk,
    input  logic i_rst_n,
    fir_in_if.sink    s_in,
    fir_out_if.source m_out
);

    logic               r_in_valid;
    fir_pkg::t_in_item  r_in;
    logic               r_out_valid;
    fir_pkg::t_out_item r_out;
    logic               out_adv;
    logic               in_adv;
    logic [63:0]        rounded;

    assign out_adv     = !r_out_valid || m_out.ready;
    assign in_adv      = !r_in_valid || out_adv;
    assign s_in.ready  = in_adv;
    assign m_out.valid = r_out_valid;
    assign m_out.data  = r_out;

    // Hold or advance the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= s_in.valid;
        end
        if (in_adv && s_in.valid) begin
            r_in <= s_in.data;
        end
    end

    fir_round u_round (
        .i_op         (r_in.op),
        .i_value_bits (r_in.value_bits),
        .o_rounded    (rounded)
    );

    // Hold or advance the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (out_adv && r_in_valid) begin
            r_out.rounded <= rounded;
        end
    end

`ifndef SYNTHESIS
    a_adv_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_adv) |=> r_out_valid)
        else $error("result stage lost a transaction");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_out.ready) |-> !s_in.ready)
        else $error("ready high with both stages full");
`endif

endmodule

[rtl/core/fir_round.sv]
// Combinational round-half-up conversion of one IEEE-754 value to an integer.
// Depends on fir_pkg.
module fir_round (
    input  logic        i_op,
    input  logic [63:0] i_value_bits,
    output logic [63:0] o_rounded
);

    logic        sign;
    logic [10:0] expo;
    logic [52:0] mant;
    logic        is_max_exp;
    logic        frac_nz;
    logic [11:0] e_eff;
    logic [11:0] unit_exp;
    logic [5:0]  sat_k;
    logic [63:0] minval;
    logic [63:0] maxval;
    logic [63:0] mag;
    logic [63:0] ip;
    logic [63:0] fr;
    logic [63:0] half;
    logic [63:0] mwide;
    logic [11:0] k;
    logic [11:0] sh;

    always_comb begin
        // Unpack fields for the selected precision
        if (i_op == fir_pkg::t_op_sgl) begin
            sign       = i_value_bits[31];
            expo       = {3'd0, i_value_bits[30:23]};
            mant       = {29'd0, (i_value_bits[30:23] != 8'd0), i_value_bits[22:0]};
            is_max_exp = (i_value_bits[30:23] == 8'hFF);
            frac_nz    = (i_value_bits[22:0] != 23'd0);
            unit_exp   = 12'd150;
            sat_k      = 6'd8;
            minval     = fir_pkg::Min32;
            maxval     = fir_pkg::Max32;
        end else begin
            sign       = i_value_bits[63];
            expo       = i_value_bits[62:52];
            mant       = {(i_value_bits[62:52] != 11'd0), i_value_bits[51:0]};
            is_max_exp = (i_value_bits[62:52] == 11'h7FF);
            frac_nz    = (i_value_bits[51:0] != 52'd0);
            unit_exp   = 12'd1075;
            sat_k      = 6'd11;
            minval     = fir_pkg::Min64;
            maxval     = fir_pkg::Max64;
        end
        e_eff = (expo != 11'd0) ? {1'b0, expo} : 12'd1;
        mwide = {11'd0, mant};
        k     = e_eff - unit_exp;
        sh    = unit_exp - e_eff;
        ip    = '0;
        fr    = '0;
        half  = '0;
        mag   = '0;

        if (is_max_exp) begin
            o_rounded = frac_nz ? 64'd0 : (sign ? minval : maxval);
        end else if (e_eff >= unit_exp) begin
            // Integer already: left shift or saturate
            if (k >= {6'd0, sat_k}) begin
                o_rounded = sign ? minval : maxval;
            end else begin
                mag       = mwide << k[5:0];
                o_rounded = sign ? (64'd0 - mag) : mag;
            end
        end else if (sh > 12'd54) begin
            o_rounded = 64'd0;
        end else begin
            // Fraction present: split and round, ties toward +inf
            ip   = mwide >> sh[5:0];
            half = 64'd1 << (sh[5:0] - 6'd1);
            fr   = mwide & ((64'd1 << sh[5:0]) - 64'd1);
            if (sign) begin
                mag = ip + ((fr > half) ? 64'd1 : 64'd0);
            end else begin
                mag = ip + ((fr >= half) ? 64'd1 : 64'd0);
            end
            o_rounded = sign ? (64'd0 - mag) : mag;
        end
    end

endmodule

[test/float_to_int_round_half_up_tb.sv]
// Testbench for float_to_int_round_half_up: directed table then random operands,
// with bursty input, patterned output stalls and one long output hold-off.
// Depends on fir_pkg, fir_in_if, fir_out_if and the block itself.
module float_to_int_round_half_up_tb;

    typedef struct {
        fir_pkg::t_op op;
        logic [63:0]  bits;
        bit           has_exp;
        logic [63:0]  exp_val;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    fir_in_if  s_in ();
    fir_out_if m_out ();

    float_to_int_round_half_up dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in.sink),
        .m_out   (m_out.source)
    );

    logic [63:0] expected_q[$];
    int          err_count;
    int          cycle_count = 0;
    bit          hold_long;
    t_row        rows[$];

    // Round to nearest, ties toward +inf, saturating at the selected width
    function automatic logic [63:0] round_value(fir_pkg::t_op op, logic [63:0] raw);
        int unsigned mb, eb, ob;
        logic [63:0] bits, sgn, emask, expo, frac, unit_e, maxmag, minv, maxv;
        logic [63:0] m, e, mag, sh, ip, fr, half;
        mb = (op == fir_pkg::t_op_dbl) ? 52 : 23;
        eb = (op == fir_pkg::t_op_dbl) ? 11 : 8;
        ob = (op == fir_pkg::t_op_dbl) ? 64 : 32;
        bits = (op == fir_pkg::t_op_dbl) ? raw : {32'd0, raw[31:0]};
        sgn = (bits >> (mb + eb)) & 64'd1;
        emask = (64'd1 << eb) - 64'd1;
        expo = (bits >> mb) & emask;
        frac = bits & ((64'd1 << mb) - 64'd1);
        unit_e = (emask >> 1) + mb;
        maxmag = 64'd1 << (ob - 1);
        minv = 64'd0 - maxmag;
        maxv = maxmag - 64'd1;
        if (expo == emask) begin
            if (frac != 0) return 64'd0;
            return sgn[0] ? minv : maxv;
        end
        m = frac | ((expo != 0) ? (64'd1 << mb) : 64'd0);
        e = (expo != 0) ? expo : 64'd1;
        if (e >= unit_e) begin
            if (e - unit_e >= ob - 1 - mb) return sgn[0] ? minv : maxv;
            mag = m << (e - unit_e);
        end else begin
            sh = unit_e - e;
            if (sh > mb + 1) return 64'd0;
            ip = m >> sh;
            fr = m & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (sgn[0]) mag = ip + ((fr > half) ? 64'd1 : 64'd0);
            else        mag = ip + ((fr >= half) ? 64'd1 : 64'd0);
        end
        return sgn[0] ? 64'd0 - mag : mag;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        err_count++;
    endtask

    // Random operand biased toward the interesting exponent window
    function automatic logic [63:0] random_bits(fir_pkg::t_op op);
        logic [63:0] v;
        int unsigned k;
        v = {$urandom, $urandom};
        k = $urandom_range(0, 9);
        if (op == fir_pkg::t_op_dbl) begin
            if (k < 6) v[62:52] = 11'(1023 - 3 + $urandom_range(0, 66));
            else if (k == 6) v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
            if (k < 3) v[51:0] = v[51:0] & ~(52'h1 << $urandom_range(0, 51)) &
                                 ({52{1'b1}} << $urandom_range(0, 51));
        end else begin
            if (k < 6) v[30:23] = 8'(127 - 3 + $urandom_range(0, 35));
            else if (k == 6) v[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if (k < 3) v[22:0] = v[22:0] & ({23{1'b1}} << $urandom_range(0, 22));
        end
        return v;
    endfunction

    task automatic add_row(fir_pkg::t_op op, logic [63:0] bits, bit has_exp = 0,
                           logic [63:0] exp_val = 0);
        t_row r;
        r.op = op; r.bits = bits; r.has_exp = has_exp; r.exp_val = exp_val;
        rows.push_back(r);
    endtask

    // Clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Check each output transaction against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_out.valid && m_out.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", m_out.data.rounded, 64'd0);
            end else begin
                if (m_out.data.rounded !== expected_q[0])
                    report_mismatch("rounded", m_out.data.rounded, expected_q[0]);
                void'(expected_q.pop_front());
            end
        end
    end

    // Receiver stall pattern, with one long hold-off
    initial begin
        int unsigned ph;
        m_out.ready = 0;
        ph = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                m_out.ready <= 0;
                repeat (60) @(negedge i_clk);
                hold_long = 0;
            end
            ph++;
            if (ph % 400 < 100) m_out.ready <= 1;
            else m_out.ready <= ((ph % 7) != 3) && ($urandom_range(0, 3) != 0);
        end
    end

    // Stimulus
    initial begin
        int unsigned burst;
        int unsigned gap;
        t_row r;
        logic [63:0] want;
        s_in.valid = 0;
        s_in.data = '0;
        i_rst_n = 0;
        err_count = 0;
        hold_long = 0;

        // Directed rows: zeros, ties, infinities, NaNs, limits, tiny, ignored bits
        add_row(fir_pkg::t_op_dbl, 64'h0000_0000_0000_0000, 1, 64'd0);
        add_row(fir_pkg::t_op_dbl, 64'h8000_0000_0000_0000, 1, 64'd0);
        add_row(fir_pkg::t_op_dbl, 64'h7FF0_0000_0000_0000, 1, fir_pkg::Max64);
        add_row(fir_pkg::t_op_dbl, 64'hFFF0_0000_0000_0000, 1, fir_pkg::Min64);
        add_row(fir_pkg::t_op_dbl, 64'h7FF8_0000_0000_0000, 1, 64'd0);
        add_row(fir_pkg::t_op_dbl, 64'hFFF0_0000_0000_0001, 1, 64'd0);
        add_row(fir_pkg::t_op_dbl, 64'h43E0_0000_0000_0000, 1, fir_pkg::Max64);
        add_row(fir_pkg::t_op_dbl, 64'hC3E0_0000_0000_0000, 1, fir_pkg::Min64);
        add_row(fir_pkg::t_op_dbl, 64'h3FE0_0000_0000_0000, 1, 64'd1);
        add_row(fir_pkg::t_op_dbl, 64'hBFE0_0000_0000_0000, 1, 64'd0);
        add_row(fir_pkg::t_op_dbl, 64'hC004_0000_0000_0000, 1, -64'sd2);
        add_row(fir_pkg::t_op_dbl, 64'hC005_9999_9999_999A);
        add_row(fir_pkg::t_op_dbl, 64'hC002_6666_6666_6666);
        add_row(fir_pkg::t_op_dbl, 64'h0000_0000_0000_0001, 1, 64'd0);
        add_row(fir_pkg::t_op_dbl, 64'h43DF_FFFF_FFFF_FFFF);
        add_row(fir_pkg::t_op_dbl, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'd0);
        add_row(fir_pkg::t_op_sgl, 64'hFFFF_FFFF_7F80_0000, 1, fir_pkg::Max32);
        add_row(fir_pkg::t_op_sgl, 64'h0000_0000_FF80_0000, 1, fir_pkg::Min32);
        add_row(fir_pkg::t_op_sgl, 64'h0000_0000_7FC0_0000, 1, 64'd0);
        add_row(fir_pkg::t_op_sgl, 64'h0000_0000_4F00_0000, 1, fir_pkg::Max32);
        add_row(fir_pkg::t_op_sgl, 64'h0000_0000_CF00_0000, 1, fir_pkg::Min32);
        add_row(fir_pkg::t_op_sgl, 64'h0000_0000_4EFF_FFFF);
        add_row(fir_pkg::t_op_sgl, 64'hABCD_0000_BF00_0000, 1, 64'd0);
        add_row(fir_pkg::t_op_sgl, 64'h0000_0000_C020_0000, 1, -64'sd2);
        add_row(fir_pkg::t_op_sgl, 64'h0000_0000_8000_0001, 1, 64'd0);
        // Random operands
        for (int i = 0; i < 1350; i++) begin
            fir_pkg::t_op op;
            op = fir_pkg::t_op'($urandom_range(0, 1));
            add_row(op, random_bits(op));
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        burst = 0;
        for (int i = 0; i < rows.size(); i++) begin
            r = rows[i];
            // Idle gap between bursts
            if (burst == 0) begin
                gap = $urandom_range(0, 4);
                if (gap > 0) begin
                    s_in.valid <= 0;
                    repeat (gap) @(negedge i_clk);
                end
                burst = $urandom_range(1, 30);
            end
            if (i == 600) hold_long = 1;
            s_in.valid <= 1;
            s_in.data.op <= r.op;
            s_in.data.value_bits <= r.bits;
            want = round_value(r.op, r.bits);
            if (r.has_exp && want !== r.exp_val)
                report_mismatch("table entry", want, r.exp_val);
            // Wait for the transaction to be accepted
            do @(posedge i_clk); while (!s_in.ready);
            expected_q.push_back(want);
            burst--;
            @(negedge i_clk);
        end
        s_in.valid <= 0;

        wait (expected_q.size() == 0);
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
